// ===== rtl/r3v_pkg.sv =====
// r3v_pkg: shared types, codes and character constants for the resp3 frame validator
// no dependencies; used by every module of the block
package r3v_pkg;

	// stack of open aggregates
	localparam int STACK_DEPTH = 16;
	localparam int LVL_W = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	// front to back queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// configuration register indexes
	localparam logic [1:0] CFG_MAX_DEPTH = 2'd0;
	localparam logic [1:0] CFG_MAX_BYTES = 2'd1;
	localparam logic [4:0] RST_MAX_DEPTH = 5'd16;
	localparam logic [31:0] RST_MAX_BYTES = 32'd536870912;

	// result status
	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_INVALID    = 2'd1,
		ST_OVERFLOW   = 2'd2,
		ST_INCOMPLETE = 2'd3
	} status_t;

	// characters
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_COLON  = 8'h3a;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_EQUAL  = 8'h3d;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_TILDE  = 8'h7e;
	localparam logic [7:0] CH_GT     = 8'h3e;
	localparam logic [7:0] CH_PIPE   = 8'h7c;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_UNDER  = 8'h5f;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_I      = 8'h69;
	localparam logic [7:0] CH_N      = 8'h6e;
	localparam logic [7:0] CH_A      = 8'h61;
	localparam logic [7:0] CH_E_LO   = 8'h65;
	localparam logic [7:0] CH_E_UP   = 8'h45;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       buffer_end;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  frame_type;
		logic [31:0] frame_bytes;
		logic [31:0] decl_count;
	} out_item_t;

	// classified byte carried through the queue
	typedef struct packed {
		in_item_t   item;
		logic       is_digit;
		logic [3:0] digit;
		logic       is_cr;
		logic       is_lf;
	} cls_item_t;

endpackage

// ===== rtl/r3v_front.sv =====
// r3v_front: accepts input transfers and classifies each byte for the back unit
// depends on r3v_pkg
module r3v_front import r3v_pkg::*; (
	input  logic      in_valid,
	input  in_item_t  in_item,
	output logic      in_stall,
	input  logic      q_full,
	output logic      q_push,
	output cls_item_t q_data
);

	// stall while the queue has no room
	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	// byte classification
	always_comb begin
		q_data.item     = in_item;
		q_data.is_digit = (in_item.data_byte >= 8'h30) && (in_item.data_byte <= 8'h39);
		q_data.digit    = in_item.data_byte[3:0];
		q_data.is_cr    = (in_item.data_byte == CH_CR);
		q_data.is_lf    = (in_item.data_byte == CH_LF);
	end

endmodule

// ===== rtl/r3v_queue.sv =====
// r3v_queue: short fifo of classified bytes between front and back
// depends on r3v_pkg
module r3v_queue import r3v_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cls_item_t push_data,
	output logic      full,
	input  logic      pop,
	output logic      not_empty,
	output cls_item_t head
);

	cls_item_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wptr_q;
	logic [QPTR_W-1:0]   rptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign full      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= push_data;
	end

endmodule

// ===== rtl/r3v_back.sv =====
// r3v_back: frame parser state, aggregate stack and result register
// depends on r3v_pkg
module r3v_back import r3v_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  cls_item_t  q_head,
	output logic       q_pop,
	input  logic [4:0] max_depth,
	input  logic [31:0] max_bytes,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_item
);

	typedef enum logic [6:0] {
		M_AWAIT   = 7'b0000001,
		M_LINE    = 7'b0000010,
		M_LINE_CR = 7'b0000100,
		M_BODY    = 7'b0001000,
		M_BCR     = 7'b0010000,
		M_BLF     = 7'b0100000,
		M_POP     = 7'b1000000
	} mode_t;

	mode_t            mode_q, n_mode;
	logic [LVL_W-1:0] level_q, n_level;
	logic [31:0]      fcount_q, n_fcount;
	logic [63:0]      acc_q, n_acc;
	logic             neg_q, n_neg;
	logic             seen_q, n_seen;
	logic [32:0]      bulk_q, n_bulk;
	logic [7:0]       ltc_q, n_ltc;
	logic [7:0]       ttype_q, n_ttype;
	logic [31:0]      tcount_q, n_tcount;
	logic             err_q, n_err;
	logic             endp_q, n_endp;
	logic [32:0]      stack_q [STACK_DEPTH];

	logic             out_valid_q;
	out_item_t        out_q;
	logic             out_free;
	logic             take;
	logic             pop_go;

	logic             res_v;
	status_t          res_st;
	out_item_t        res_item;
	logic             cpl;
	logic             fail;
	logic             sw_en;
	logic [IDX_W-1:0] sw_idx;
	logic [32:0]      sw_data;

	logic [7:0]       c;
	logic             fresh;
	logic [31:0]      fc;
	logic [7:0]       lim;
	logic [7:0]       cdepth;
	logic             int_line;
	logic             checked_line;
	logic             line_ok;
	logic             is_sign;
	logic             is_e;
	logic [63:0]      ilim;
	logic [67:0]      inext;
	logic             bneg;
	logic [32:0]      mag2;
	logic [IDX_W-1:0] pidx;
	logic [32:0]      pval;
	logic [LVL_W-1:0] lvl_m1;

	assign out_free  = !out_valid_q || !out_stall;
	assign take      = q_valid && out_free && (mode_q != M_POP);
	assign pop_go    = out_free && (mode_q == M_POP);
	assign q_pop     = take;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// byte and line classification
	always_comb begin
		c        = q_head.item.data_byte;
		int_line = (ltc_q == CH_COLON) || (ltc_q == CH_DOLLAR) || (ltc_q == CH_BANG) ||
			(ltc_q == CH_EQUAL) || (ltc_q == CH_STAR) || (ltc_q == CH_PCT) ||
			(ltc_q == CH_TILDE) || (ltc_q == CH_GT) || (ltc_q == CH_PIPE);
		checked_line = int_line || (ltc_q == CH_HASH) || (ltc_q == CH_COMMA);
		is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
		is_e     = (c == CH_E_LO) || (c == CH_E_UP);
		lim      = ({3'b0, max_depth} < 8'(STACK_DEPTH)) ? {3'b0, max_depth}
			: 8'(STACK_DEPTH);
		cdepth   = 8'(level_q);
		ilim     = neg_q ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
		inext    = {1'b0, acc_q, 3'b0} + {3'b0, acc_q, 1'b0} + {64'b0, q_head.digit};
		bneg     = neg_q && (acc_q != '0);
		mag2     = ((ltc_q == CH_PCT) || (ltc_q == CH_PIPE)) ? {acc_q[31:0], 1'b0}
			: {1'b0, acc_q[31:0]};
		pidx     = IDX_W'(level_q - 1'b1);
		pval     = stack_q[pidx] - 1'b1;
		lvl_m1   = level_q - 1'b1;
		if (ltc_q == CH_COMMA) begin
			line_ok = (((acc_q == 64'd2) || (acc_q == 64'd3)) && seen_q) ||
				(acc_q == 64'd6) || (acc_q == 64'd9) || (acc_q == 64'd12);
		end else if (checked_line) begin
			line_ok = seen_q;
		end else begin
			line_ok = 1'b1;
		end
	end

	// next parse state
	always_comb begin
		n_mode   = mode_q;
		n_level  = level_q;
		n_fcount = fcount_q;
		n_acc    = acc_q;
		n_neg    = neg_q;
		n_seen   = seen_q;
		n_bulk   = bulk_q;
		n_ltc    = ltc_q;
		n_ttype  = ttype_q;
		n_tcount = tcount_q;
		n_err    = err_q;
		n_endp   = endp_q;
		res_v    = 1'b0;
		res_st   = ST_OK;
		res_item = '0;
		cpl      = 1'b0;
		fail     = 1'b0;
		sw_en    = 1'b0;
		sw_idx   = IDX_W'(level_q);
		sw_data  = mag2;
		fresh    = (mode_q == M_AWAIT) && (level_q == '0);
		fc       = fresh ? 32'd0 : fcount_q;

		if (take && q_head.item.byte_valid && !err_q) begin
			if (fresh) begin
				n_ttype  = c;
				n_tcount = '0;
			end
			if ((mode_q == M_AWAIT) && (cdepth >= lim)) begin
				res_v  = 1'b1;
				res_st = ST_OVERFLOW;
			end else if (({1'b0, fc} + 33'd1) > {1'b0, max_bytes}) begin
				res_v  = 1'b1;
				res_st = ST_OVERFLOW;
			end else begin
				n_fcount = fc + 32'd1;
				unique case (mode_q)
					M_AWAIT: begin
						if ((c == CH_COLON) || (c == CH_DOLLAR) || (c == CH_BANG) ||
							(c == CH_EQUAL) || (c == CH_STAR) || (c == CH_PCT) ||
							(c == CH_TILDE) || (c == CH_GT) || (c == CH_PIPE) ||
							(c == CH_PLUS) || (c == CH_MINUS) || (c == CH_HASH) ||
							(c == CH_COMMA) || (c == CH_LPAREN) || (c == CH_UNDER)) begin
							n_ltc  = c;
							n_acc  = '0;
							n_neg  = 1'b0;
							n_seen = 1'b0;
							n_mode = M_LINE;
						end else begin
							res_v  = 1'b1;
							res_st = ST_INVALID;
						end
					end
					M_LINE, M_LINE_CR: begin
						if ((mode_q == M_LINE_CR) && q_head.is_lf) begin
							// line complete
							if (!line_ok) begin
								res_v  = 1'b1;
								res_st = ST_INVALID;
							end else if (!int_line || (ltc_q == CH_COLON)) begin
								cpl = 1'b1;
							end else if ((ltc_q == CH_DOLLAR) || (ltc_q == CH_BANG) ||
								(ltc_q == CH_EQUAL)) begin
								if (bneg) begin
									if (acc_q == 64'd1) begin
										cpl = 1'b1;
									end else begin
										res_v  = 1'b1;
										res_st = ST_OVERFLOW;
									end
								end else if (acc_q > {32'b0, max_bytes}) begin
									res_v  = 1'b1;
									res_st = ST_OVERFLOW;
								end else begin
									n_bulk = acc_q[32:0];
									n_mode = (acc_q == '0) ? M_BCR : M_BODY;
								end
							end else if (bneg) begin
								if ((ltc_q == CH_STAR) && (acc_q == 64'd1)) begin
									cpl = 1'b1;
								end else begin
									res_v  = 1'b1;
									res_st = ST_INVALID;
								end
							end else if (acc_q[63:32] != '0) begin
								res_v  = 1'b1;
								res_st = ST_OVERFLOW;
							end else begin
								if (level_q == '0) n_tcount = acc_q[31:0];
								if (mag2 == '0) begin
									cpl = 1'b1;
								end else begin
									sw_en   = 1'b1;
									n_level = level_q + 1'b1;
									n_mode  = M_AWAIT;
								end
							end
						end else if ((mode_q == M_LINE) && q_head.is_cr) begin
							n_mode = M_LINE_CR;
						end else if ((mode_q == M_LINE_CR) && checked_line) begin
							// a pending cr is payload, which checked lines reject
							res_v  = 1'b1;
							res_st = ST_INVALID;
						end else if ((mode_q == M_LINE_CR) && q_head.is_cr) begin
							n_mode = M_LINE_CR;
						end else begin
							n_mode = M_LINE;
							// payload character
							if (int_line) begin
								if (c == CH_MINUS) begin
									if (seen_q || neg_q) fail = 1'b1;
									n_neg = 1'b1;
								end else if (!q_head.is_digit) begin
									fail = 1'b1;
								end else if (inext > {4'b0, ilim}) begin
									fail = 1'b1;
								end else begin
									n_acc  = inext[63:0];
									n_seen = 1'b1;
								end
							end else if (ltc_q == CH_HASH) begin
								if (seen_q || ((c != CH_T) && (c != CH_F))) fail = 1'b1;
								n_seen = 1'b1;
							end else if (ltc_q == CH_COMMA) begin
								if ((acc_q == 64'd0) && is_sign) begin
									n_acc = 64'd1;
								end else if ((acc_q == 64'd0) && (c == CH_N)) begin
									n_acc = 64'd10;
								end else if ((acc_q == 64'd0) || (acc_q == 64'd1)) begin
									if (c == CH_I) n_acc = 64'd7;
									else if (q_head.is_digit) begin
										n_acc  = 64'd2;
										n_seen = 1'b1;
									end else if (c == CH_DOT) n_acc = 64'd3;
									else fail = 1'b1;
								end else if ((acc_q == 64'd2) || (acc_q == 64'd3)) begin
									if (q_head.is_digit) n_seen = 1'b1;
									else if ((acc_q == 64'd2) && (c == CH_DOT)) n_acc = 64'd3;
									else if (is_e && seen_q) n_acc = 64'd4;
									else fail = 1'b1;
								end else if ((acc_q == 64'd4) && is_sign) begin
									n_acc = 64'd5;
								end else if ((acc_q >= 64'd4) && (acc_q <= 64'd6)) begin
									if (q_head.is_digit) n_acc = 64'd6;
									else fail = 1'b1;
								end else if ((acc_q == 64'd7) && (c == CH_N)) begin
									n_acc = 64'd8;
								end else if ((acc_q == 64'd8) && (c == CH_F)) begin
									n_acc = 64'd9;
								end else if ((acc_q == 64'd10) && (c == CH_A)) begin
									n_acc = 64'd11;
								end else if ((acc_q == 64'd11) && (c == CH_N)) begin
									n_acc = 64'd12;
								end else begin
									fail = 1'b1;
								end
							end
							if (fail) begin
								res_v  = 1'b1;
								res_st = ST_INVALID;
							end
						end
					end
					M_BODY: begin
						n_bulk = bulk_q - 1'b1;
						if (n_bulk == '0) n_mode = M_BCR;
					end
					M_BCR: begin
						n_neg  = q_head.is_cr;
						n_mode = M_BLF;
					end
					M_BLF: begin
						if (neg_q && q_head.is_lf) begin
							cpl = 1'b1;
						end else begin
							res_v  = 1'b1;
							res_st = ST_INVALID;
						end
					end
					default: begin
						n_mode = M_AWAIT;
					end
				endcase
			end
			// a finished child ends a top-level frame or starts an unwind of its parents
			if (cpl) begin
				if (level_q == '0) begin
					res_v  = 1'b1;
					res_st = ST_OK;
				end else begin
					n_mode = M_POP;
				end
			end
		end else if (pop_go) begin
			// unwind one stack level per cycle while the output is free
			sw_en   = 1'b1;
			sw_idx  = pidx;
			sw_data = pval;
			if (pval != '0) begin
				n_mode = M_AWAIT;
			end else begin
				n_level = lvl_m1;
				if (lvl_m1 == '0) begin
					res_v  = 1'b1;
					res_st = ST_OK;
				end
			end
		end

		// result capture
		if (res_v) begin
			res_item.status      = res_st;
			res_item.frame_type  = n_ttype;
			res_item.frame_bytes = (res_st == ST_OK) ? n_fcount : 32'd0;
			res_item.decl_count  = n_tcount;
			n_mode  = M_AWAIT;
			n_level = '0;
			if (res_st != ST_OK) n_err = 1'b1;
		end

		// buffer end, deferred until any unwind finishes
		if ((take && q_head.item.buffer_end) || (pop_go && endp_q && (n_mode != M_POP))) begin
			if (n_mode == M_POP) begin
				n_endp = 1'b1;
			end else begin
				if (!res_v && !n_err && ((n_mode != M_AWAIT) || (n_level != '0))) begin
					res_v                = 1'b1;
					res_item.status      = ST_INCOMPLETE;
					res_item.frame_type  = n_ttype;
					res_item.frame_bytes = '0;
					res_item.decl_count  = n_tcount;
				end
				n_mode   = M_AWAIT;
				n_level  = '0;
				n_fcount = '0;
				n_acc    = '0;
				n_neg    = 1'b0;
				n_seen   = 1'b0;
				n_bulk   = '0;
				n_ltc    = '0;
				n_ttype  = '0;
				n_tcount = '0;
				n_err    = 1'b0;
				n_endp   = 1'b0;
			end
		end
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= M_AWAIT;
			level_q     <= '0;
			fcount_q    <= '0;
			acc_q       <= '0;
			neg_q       <= 1'b0;
			seen_q      <= 1'b0;
			bulk_q      <= '0;
			ltc_q       <= '0;
			ttype_q     <= '0;
			tcount_q    <= '0;
			err_q       <= 1'b0;
			endp_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mode_q   <= n_mode;
			level_q  <= n_level;
			fcount_q <= n_fcount;
			acc_q    <= n_acc;
			neg_q    <= n_neg;
			seen_q   <= n_seen;
			bulk_q   <= n_bulk;
			ltc_q    <= n_ltc;
			ttype_q  <= n_ttype;
			tcount_q <= n_tcount;
			err_q    <= n_err;
			endp_q   <= n_endp;
			if (out_free) out_valid_q <= res_v;
		end
	end

	// result payload and child count stack
	always_ff @(posedge clk) begin
		if (out_free && res_v) out_q <= res_item;
		if (sw_en) stack_q[sw_idx] <= sw_data;
	end

`ifndef SYNTHESIS
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LVL_W'(STACK_DEPTH))
		else $error("stack level beyond depth");
	a_pop_level: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_POP) |-> (level_q != '0))
		else $error("unwind with empty stack");
	a_err_idle: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |-> ((mode_q == M_AWAIT) && (level_q == '0)))
		else $error("error hold with open frame");
	a_pop_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_POP) |-> !q_pop)
		else $error("byte taken during unwind");
`endif

endmodule

// ===== rtl/resp3_frame_validator.sv =====
// RESP3 frame validator. Bytes arrive one per transfer and are classified by a front stage
// into a four-entry queue; the back unit keeps open aggregate child counts on a 16-entry
// stack and parses one byte per cycle, sustained one byte per clock, unless it is unwinding
// or the output stalls. When a child frame ends inside open aggregates, the back unit stops
// taking bytes and unwinds one stack level per cycle, for the parent's count and each
// further aggregate that the child closes; the queue absorbs that while input keeps flowing
// until it fills. At most one result per top-level frame, held in an output register.
// Configuration writes are always ready and must only be issued while the block is idle.
// depends on r3v_pkg, r3v_front, r3v_queue, r3v_back
module resp3_frame_validator import r3v_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_item,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic        max_depth_q;
	logic [4:0]  depth_q;
	logic [31:0] bytes_q;
	logic        q_full;
	logic        q_push;
	cls_item_t   q_in;
	logic        q_pop;
	logic        q_valid;
	cls_item_t   q_head;

	assign cfg_ready   = 1'b1;
	assign max_depth_q = (depth_q != '0);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= RST_MAX_DEPTH;
			bytes_q <= RST_MAX_BYTES;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAX_DEPTH: depth_q <= cfg_data[4:0];
				CFG_MAX_BYTES: bytes_q <= cfg_data;
				default: ;
			endcase
		end
	end

	r3v_front u_front (
		.in_valid (in_valid),
		.in_item  (in_item),
		.in_stall (in_stall),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_in)
	);

	r3v_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	r3v_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.max_depth (max_depth_q ? depth_q : 5'd0),
		.max_bytes (bytes_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

// ===== sim/tb.sv =====
// tb: self-checking testbench for resp3_frame_validator, built around a byte-level frame predictor
// generates RESP3 traffic, directed corner frames first and then random and directed frames under several settings
// depends on r3v_pkg and the resp3_frame_validator rtl
`timescale 1ns / 100ps

module tb;
	import r3v_pkg::*;

	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam string CRLF = "\015\012";
	localparam int DRAIN_CYCLES = 40;

	typedef enum int {M_AWAIT, M_LINE, M_LINE_CR, M_BODY, M_BODY_CR, M_BODY_LF} pmode_t;
	typedef enum int {
		D_START, D_SIGN, D_INT, D_FRAC, D_EXP, D_EXPSIGN, D_EXPDIG,
		D_I, D_IN, D_INF, D_N, D_NA, D_NAN
	} dphase_t;

	// frame predictor and store of expected frame reports
	class frame_scoreboard;
		logic [4:0]  max_depth;
		logic [31:0] max_bytes;
		pmode_t      mode;
		dphase_t     dph;
		logic [63:0] child_left[STACK_DEPTH];
		int          lvl;
		logic [31:0] fcount;
		logic [63:0] acc;
		bit          neg, seen, err_hold;
		logic [63:0] bulk_left;
		logic [7:0]  ltype, top_type;
		logic [31:0] top_count;
		out_item_t   reports_q[$];
		int          errors;

		function new();
			max_depth = RST_MAX_DEPTH;
			max_bytes = RST_MAX_BYTES;
			errors = 0;
			restart();
		endfunction

		function void restart();
			mode = M_AWAIT;
			dph = D_START;
			lvl = 0;
			fcount = 0;
			acc = 0;
			neg = 0;
			seen = 0;
			bulk_left = 0;
			ltype = 0;
			top_type = 0;
			top_count = 0;
			err_hold = 0;
		endfunction

		function int pending();
			return reports_q.size();
		endfunction

		function bit is_num_line(logic [7:0] c);
			return c inside {CH_COLON, CH_DOLLAR, CH_BANG, CH_EQUAL, CH_STAR,
				CH_PCT, CH_TILDE, CH_GT, CH_PIPE};
		endfunction

		function bit is_dig(logic [7:0] c);
			return c >= CH_0 && c <= CH_9;
		endfunction

		function int emit(status_t st);
			out_item_t r;
			r.status = st;
			r.frame_type = top_type;
			r.frame_bytes = (st == ST_OK) ? fcount : 32'd0;
			r.decl_count = top_count;
			reports_q.push_back(r);
			mode = M_AWAIT;
			lvl = 0;
			if (st != ST_OK) err_hold = 1;
			return 1;
		endfunction

		// signed 64-bit decimal accumulation
		function bit feed_int(logic [7:0] c);
			logic [63:0] lim, d;
			if (c == CH_MINUS) begin
				if (seen || neg) return 0;
				neg = 1;
				return 1;
			end
			if (!is_dig(c)) return 0;
			lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
			d = 64'(c - CH_0);
			if (acc > (lim - d) / 10) return 0;
			acc = acc * 10 + d;
			seen = 1;
			return 1;
		endfunction

		// double syntax walk
		function bit feed_double(logic [7:0] c);
			bit e, sgn, dg;
			e = (c == CH_E_LO || c == CH_E_UP);
			sgn = (c == CH_PLUS || c == CH_MINUS);
			dg = is_dig(c);
			if (dph == D_START && sgn) begin dph = D_SIGN; return 1; end
			if (dph == D_START && c == CH_N) begin dph = D_N; return 1; end
			if (dph == D_START || dph == D_SIGN) begin
				if (c == CH_I) dph = D_I;
				else if (dg) begin dph = D_INT; seen = 1; end
				else if (c == CH_DOT) dph = D_FRAC;
				else return 0;
				return 1;
			end
			if (dph == D_INT || dph == D_FRAC) begin
				if (dg) begin seen = 1; return 1; end
				if (dph == D_INT && c == CH_DOT) begin dph = D_FRAC; return 1; end
				if (e && seen) begin dph = D_EXP; return 1; end
				return 0;
			end
			if (dph == D_EXP && sgn) begin dph = D_EXPSIGN; return 1; end
			if (dph == D_EXP || dph == D_EXPSIGN || dph == D_EXPDIG) begin
				if (dg) begin dph = D_EXPDIG; return 1; end
				return 0;
			end
			if (dph == D_I && c == CH_N) begin dph = D_IN; return 1; end
			if (dph == D_IN && c == CH_F) begin dph = D_INF; return 1; end
			if (dph == D_N && c == CH_A) begin dph = D_NA; return 1; end
			if (dph == D_NA && c == CH_N) begin dph = D_NAN; return 1; end
			return 0;
		endfunction

		function bit feed(logic [7:0] c);
			if (is_num_line(ltype)) return feed_int(c);
			if (ltype == CH_HASH) begin
				if (seen || (c != CH_T && c != CH_F)) return 0;
				seen = 1;
				return 1;
			end
			if (ltype == CH_COMMA) return feed_double(c);
			return 1;
		endfunction

		// a child finished: unwind every aggregate it closes
		function int complete();
			int i;
			mode = M_AWAIT;
			forever begin
				if (lvl == 0) return emit(ST_OK);
				i = (lvl - 1) % STACK_DEPTH;
				child_left[i] = child_left[i] - 1;
				if (child_left[i] != 0) return 0;
				lvl--;
			end
		endfunction

		function int end_line();
			bit ok, nv;
			logic [63:0] mag;
			if (is_num_line(ltype) || ltype == CH_HASH) ok = seen;
			else if (ltype == CH_COMMA)
				ok = ((dph == D_INT || dph == D_FRAC) && seen) || dph == D_EXPDIG ||
					dph == D_INF || dph == D_NAN;
			else ok = 1;
			if (!ok) return emit(ST_INVALID);
			if (!is_num_line(ltype) || ltype == CH_COLON) return complete();
			nv = neg && acc != 0;
			mag = acc;
			// bulk length line
			if (ltype inside {CH_DOLLAR, CH_BANG, CH_EQUAL}) begin
				if (nv) return (mag == 1) ? complete() : emit(ST_OVERFLOW);
				if (mag > {32'd0, max_bytes}) return emit(ST_OVERFLOW);
				bulk_left = mag;
				mode = (mag == 0) ? M_BODY_CR : M_BODY;
				return 0;
			end
			// aggregate count line
			if (nv) return (ltype == CH_STAR && mag == 1) ? complete() : emit(ST_INVALID);
			if (mag > 64'hffff_ffff) return emit(ST_OVERFLOW);
			if (lvl == 0) top_count = mag[31:0];
			if (ltype == CH_PCT || ltype == CH_PIPE) mag = mag * 2;
			if (mag == 0) return complete();
			child_left[lvl % STACK_DEPTH] = mag;
			lvl++;
			mode = M_AWAIT;
			return 0;
		endfunction

		function int take_byte(logic [7:0] c);
			int lim;
			lim = (max_depth < STACK_DEPTH) ? int'(max_depth) : STACK_DEPTH;
			if (mode == M_AWAIT) begin
				if (lvl == 0) begin
					top_type = c;
					top_count = 0;
					fcount = 0;
				end
				if (lvl >= lim) return emit(ST_OVERFLOW);
			end
			if ({1'b0, fcount} + 33'd1 > {1'b0, max_bytes}) return emit(ST_OVERFLOW);
			fcount++;
			case (mode)
				M_AWAIT: begin
					if (!(is_num_line(c) || c inside {CH_PLUS, CH_MINUS, CH_HASH, CH_COMMA,
						CH_LPAREN, CH_UNDER}))
						return emit(ST_INVALID);
					ltype = c;
					acc = 0;
					neg = 0;
					seen = 0;
					dph = D_START;
					mode = M_LINE;
					return 0;
				end
				M_LINE: begin
					if (c == CH_CR) begin mode = M_LINE_CR; return 0; end
					return feed(c) ? 0 : emit(ST_INVALID);
				end
				M_LINE_CR: begin
					if (c == CH_LF) return end_line();
					if (!feed(CH_CR)) return emit(ST_INVALID);
					if (c == CH_CR) return 0;
					mode = M_LINE;
					return feed(c) ? 0 : emit(ST_INVALID);
				end
				M_BODY: begin
					bulk_left = bulk_left - 1;
					if (bulk_left == 0) mode = M_BODY_CR;
					return 0;
				end
				M_BODY_CR: begin
					neg = (c == CH_CR);
					mode = M_BODY_LF;
					return 0;
				end
				default: begin
					if (neg && c == CH_LF) return complete();
					return emit(ST_INVALID);
				end
			endcase
		endfunction

		// accepted input transfer
		function void note_input(in_item_t it);
			int n;
			n = 0;
			if (it.byte_valid && !err_hold) n = take_byte(it.data_byte);
			if (it.buffer_end) begin
				if (n == 0 && !err_hold && (mode != M_AWAIT || lvl != 0))
					void'(emit(ST_INCOMPLETE));
				restart();
			end
		endfunction

		// accepted output transfer
		function void check_result(out_item_t got);
			out_item_t want;
			if (reports_q.size() == 0) begin
				$error("unexpected frame report %h", got);
				errors++;
				return;
			end
			want = reports_q.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d actual %0d", want.status, got.status);
				errors++;
			end
			if (got.frame_type !== want.frame_type) begin
				$error("frame_type: expected %h actual %h", want.frame_type, got.frame_type);
				errors++;
			end
			if (got.frame_bytes !== want.frame_bytes) begin
				$error("frame_bytes: expected %0d actual %0d", want.frame_bytes, got.frame_bytes);
				errors++;
			end
			if (got.decl_count !== want.decl_count) begin
				$error("decl_count: expected %0d actual %0d", want.decl_count,
					got.decl_count);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_item;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_MAX_DEPTH;
	logic [31:0] cfg_data = '0;

	frame_scoreboard sb;
	logic [7:0] stream_q[$];
	int  sent = 0;
	bit  quiet = 0;
	bit  hold_req = 0;

	resp3_frame_validator u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("tb: FAIL");
		$finish;
	end

	// output side: random stall bursts, one long hold on request
	initial begin
		int k;
		k = 0;
		forever begin
			@(posedge clk);
			k++;
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (150) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 0;
			end else if (!quiet && (k / 300) % 3 != 1 && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall && sb != null) sb.check_result(out_item);
	end

	task automatic send_item(logic [7:0] b, bit bv, bit be);
		in_item_t it;
		it.data_byte = b;
		it.byte_valid = bv;
		it.buffer_end = be;
		// random sender gaps, with calm stretches
		if (!quiet && (sent / 200) % 3 != 2 && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_item <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_input(it);
		sent++;
	endtask

	// send the queued stream as one buffer, closed by buffer_end
	task automatic send_buffer();
		bit end_empty;
		end_empty = ($urandom_range(0, 7) == 0);
		for (int i = 0; i < stream_q.size(); i++) begin
			if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
			send_item(stream_q[i], 1'b1, !end_empty && i == stream_q.size() - 1);
		end
		if (end_empty || stream_q.size() == 0) send_item(8'($urandom), 1'b0, 1'b1);
		stream_q.delete();
	endtask

	function automatic void put(string s);
		foreach (s[i]) stream_q.push_back(s[i]);
	endfunction

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_MAX_DEPTH) sb.max_depth = val[4:0];
		else sb.max_bytes = val;
	endtask

	task automatic set_limits(logic [4:0] depth, logic [31:0] nbytes);
		drain();
		write_reg(CFG_MAX_DEPTH, 32'(depth));
		write_reg(CFG_MAX_BYTES, nbytes);
	endtask

	task automatic directed_frame(string s);
		put(s);
		send_buffer();
	endtask

	function automatic string rand_int_text(bit good);
		case ($urandom_range(0, 5))
			0: return good ? "-9223372036854775808" : "9223372036854775808";
			1: return $sformatf("%0d", $signed({$urandom, $urandom}));
			2: return good ? $sformatf("-%0d", $urandom_range(0, 999)) : "1-2";
			default: return good ? $sformatf("%0d", $urandom_range(0, 999)) : "x";
		endcase
	endfunction

	function automatic string rand_text();
		string s;
		s = "";
		repeat ($urandom_range(0, 5)) begin
			case ($urandom_range(0, 4))
				0: s = {s, "\015"};
				default: s = {s, string'(8'($urandom_range(32, 126)))};
			endcase
		end
		return s;
	endfunction

	// random frame, mostly well formed
	function automatic void gen_frame(int depth);
		bit good;
		int cnt, kids;
		string tsel;
		string dbl_ok[$] = '{"1.5", "-2", "3.25e10", "1E-3", ".5", "+7.e+2", "inf", "+inf",
			"-inf", "nan"};
		string dbl_bad[$] = '{"1e", ".", "in", "na", "1.2.3", "e5", "-", "nanx"};
		string types[$] = '{"*", "~", ">", "%", "|"};
		good = ($urandom_range(0, 11) != 0);
		case ($urandom_range(0, 13))
			0: put({":", rand_int_text(good), CRLF});
			1: put({"+", rand_text(), CRLF});
			2: put({"-", rand_text(), CRLF});
			3: put({"#", good ? ($urandom_range(0, 1) ? "t" : "f") : "tf", CRLF});
			4: put({",", good ? dbl_ok[$urandom_range(0, dbl_ok.size() - 1)]
				: dbl_bad[$urandom_range(0, dbl_bad.size() - 1)], CRLF});
			5: put({"(", rand_text(), CRLF});
			6: put({"_", CRLF});
			7, 8, 9: begin
				put(($urandom_range(0, 2) == 0) ? "$" : ($urandom_range(0, 1) ? "!" : "="));
				if ($urandom_range(0, 7) == 0) put({good ? "-1" : "-3", CRLF});
				else begin
					cnt = $urandom_range(0, 6);
					put({$sformatf("%0d", cnt), CRLF});
					repeat (cnt) stream_q.push_back(8'($urandom));
					put(good ? CRLF : "x\012");
				end
			end
			default: begin
				if ($urandom_range(0, 9) == 0) put({"*", good ? "-1" : "-2", CRLF});
				else if (!good) put({types[$urandom_range(0, 4)], "4294967296", CRLF});
				else begin
					cnt = (depth > 4) ? 0 : $urandom_range(0, 3);
					tsel = types[$urandom_range(0, 4)];
					put({tsel, $sformatf("%0d", cnt), CRLF});
					// maps and attributes carry a key and a value per entry
					kids = (tsel == "%" || tsel == "|") ? 2 * cnt : cnt;
					repeat (kids) gen_frame(depth + 1);
				end
			end
		endcase
		// occasional stray byte where a type byte is due
		if ($urandom_range(0, 40) == 0) stream_q.push_back(8'($urandom));
	endfunction

	task automatic run_random(int n_items, bit last_phase, bit with_hold);
		int target, nfr;
		target = sent + n_items;
		while (sent < target) begin
			if (last_phase && target - sent < 200) quiet = 1;
			if (with_hold && !hold_req && sent + n_items / 2 >= target && n_items > 0) begin
				hold_req = 1;
				with_hold = 0;
			end
			if ($urandom_range(0, 19) == 0) begin
				repeat ($urandom_range(1, 8)) stream_q.push_back(8'($urandom));
			end else begin
				nfr = $urandom_range(1, 3);
				repeat (nfr) gen_frame(0);
				// cut the buffer off mid-frame now and then
				if ($urandom_range(0, 9) == 0 && stream_q.size() > 1)
					stream_q = stream_q[0:$urandom_range(0, stream_q.size() - 2)];
			end
			send_buffer();
		end
	endtask

	initial begin
		string chain;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed corner frames under reset settings
		directed_frame({":-9223372036854775808", CRLF});
		directed_frame({":9223372036854775807", CRLF});
		directed_frame({":9223372036854775808", CRLF});
		directed_frame({"+a\015b", CRLF});
		directed_frame({"#t", CRLF});
		directed_frame({"#x", CRLF});
		directed_frame({",-inf", CRLF});
		directed_frame({",-1.5E+3", CRLF});
		directed_frame({"(123", CRLF, "_", CRLF});
		directed_frame({"$-1", CRLF, "$3", CRLF, "a\015b", CRLF});
		directed_frame({"=2", CRLF, "abcd"});
		directed_frame({"*-1", CRLF, "*-2", CRLF});
		directed_frame({"~4294967296", CRLF});
		directed_frame({"%1", CRLF, ":1", CRLF, "|0", CRLF, ">0", CRLF});
		directed_frame({"?", CRLF});
		directed_frame({"*2", CRLF, ":1"});
		stream_q.push_back(8'h00);
		stream_q.push_back(8'hff);
		send_buffer();
		chain = "";
		repeat (17) chain = {chain, "*1", CRLF};
		directed_frame({chain, ":1", CRLF});

		// register extremes and several working points
		set_limits(5'd0, 32'd0);
		put({":1", CRLF});
		send_buffer();
		run_random(40, 0, 0);
		set_limits(5'd16, 32'hffff_ffff);
		directed_frame({chain, ":1", CRLF});
		run_random(400, 0, 1);
		set_limits(5'd31, 32'd12);
		directed_frame({chain, ":1", CRLF});
		run_random(250, 0, 0);
		set_limits(5'd3, 32'd64);
		run_random(300, 0, 0);
		set_limits(5'd1, 32'd200);
		run_random(200, 0, 0);
		set_limits(RST_MAX_DEPTH, RST_MAX_BYTES);
		run_random(350, 1, 0);

		drain();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
